// ----- sv/rti_pkg.sv -----
// Shared types, constants and arithmetic helpers of the ray/triangle intersection unit.
`default_nettype none

package rti_pkg;

  localparam int CW   = 20;            // coordinate width
  localparam int CF   = 8;             // coordinate fraction bits
  localparam int NW   = 16;            // normal / texcoord width
  localparam int WF   = 16;            // barycentric weight fraction bits
  localparam int EW   = CW + 1;        // edge vector width
  localparam int PW   = 2 * EW + 1;    // cross product width
  localparam int DOTW = PW + EW + 2;   // dot product width
  localparam int QB   = CW + 1;        // quotient bits per division
  localparam int RW   = DOTW + QB;     // divider remainder width
  localparam int GW   = WF + 2;        // signed weight width
  localparam int LPW  = GW + NW;       // weight times attribute
  localparam int LSW  = LPW + 2;       // sum of three of those
  localparam int TPW  = 2 * CW;        // t times direction
  localparam int NATTR = 5;            // three normal components, u, v

  typedef logic signed [CW-1:0]   coord_t;
  typedef logic signed [EW-1:0]   edge_t;
  typedef logic signed [PW-1:0]   cross_t;
  typedef logic signed [DOTW-1:0] dot_t;
  typedef logic [RW-1:0]          rem_t;
  typedef logic signed [NW-1:0]   attr_t;
  typedef logic signed [GW-1:0]   wgt_t;

  localparam dot_t DET_EPS = dot_t'((64'd1 << (3 * CF)) / 64'd10000);

  typedef enum logic [3:0] {
    REG_VERTEX_A   = 4'd0,
    REG_VERTEX_B   = 4'd1,
    REG_VERTEX_C   = 4'd2,
    REG_NORMAL_A   = 4'd3,
    REG_NORMAL_B   = 4'd4,
    REG_NORMAL_C   = 4'd5,
    REG_TEXCOORD_AB = 4'd6,
    REG_TEXCOORD_C = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    coord_t [2:0] va;
    coord_t [2:0] vb;
    coord_t [2:0] vc;
    attr_t  [2:0] na;
    attr_t  [2:0] nb;
    attr_t  [2:0] nc;
    attr_t  [1:0] ta;
    attr_t  [1:0] tb;
    attr_t  [1:0] tc;
  } cfg_t;

  typedef struct packed {
    coord_t [2:0] org;
    coord_t [2:0] dir;
    coord_t       t_lo;
    coord_t       t_hi;
  } ray_in_t;

  typedef struct packed {
    ray_in_t         ray;
    logic [DOTW-1:0] det;
    dot_t            nt;
    dot_t            nx;
    dot_t            ny;
    logic            early_miss;
  } ray_job_t;

  typedef struct packed {
    logic         hit;
    coord_t       t;
    coord_t [2:0] point;
    attr_t  [2:0] shade;
    attr_t  [1:0] tex;
  } ray_res_t;

  typedef struct packed {
    logic take;
    rem_t rem;
  } div_step_t;

  function automatic cross_t cross_term(edge_t a1, edge_t b2, edge_t a2, edge_t b1);
    cross_t r;
    r = cross_t'(a1) * cross_t'(b2) - cross_t'(a2) * cross_t'(b1);
    return r;
  endfunction

  function automatic div_step_t div_step(rem_t rem, rem_t dsh);
    div_step_t r;
    r.take = (rem >= dsh);
    r.rem  = r.take ? rem - dsh : rem;
    return r;
  endfunction

  function automatic coord_t sat_coord(logic signed [TPW:0] v);
    coord_t cmax;
    coord_t cmin;
    cmax = {1'b0, {(CW-1){1'b1}}};
    cmin = {1'b1, {(CW-1){1'b0}}};
    if (v > (TPW+1)'(cmax)) begin
      return cmax;
    end else if (v < (TPW+1)'(cmin)) begin
      return cmin;
    end
    return v[CW-1:0];
  endfunction

  function automatic attr_t sat_attr(logic signed [LSW-1:0] v);
    attr_t amax;
    attr_t amin;
    amax = {1'b0, {(NW-1){1'b1}}};
    amin = {1'b1, {(NW-1){1'b0}}};
    if (v > LSW'(amax)) begin
      return amax;
    end else if (v < LSW'(amin)) begin
      return amin;
    end
    return v[NW-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/rti_front.sv -----
// Front pipeline: edge vectors, cross and dot products, sign fix and early miss test.
`default_nettype none

module rti_front import rti_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_t     cfg_i,
  input  wire logic     adv_i,
  input  wire logic     take_i,
  input  wire ray_in_t  ray_i,
  output logic          job_valid_o,
  output ray_job_t      job_o
);

  edge_t [2:0] e1, e2;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = edge_t'(cfg_i.vb[i]) - edge_t'(cfg_i.va[i]);
      e2[i] = edge_t'(cfg_i.vc[i]) - edge_t'(cfg_i.va[i]);
    end
  end

  logic v0_q, v1_q, v2_q, v3_q, v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv_i) begin
      v0_q <= take_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // stage 0: origin relative to vertex a
  ray_in_t r0_q;
  edge_t [2:0] tv0_q, tv0_d;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tv0_d[i] = edge_t'(ray_i.org[i]) - edge_t'(cfg_i.va[i]);
    end
  end

  // stage 1: P = D x E2, Q = T x E1
  ray_in_t r1_q;
  edge_t [2:0] tv1_q, dv0;
  cross_t [2:0] p1_q, q1_q, p1_d, q1_d;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv0[i] = edge_t'(r0_q.dir[i]);
    end
    p1_d[0] = cross_term(dv0[1], e2[2], dv0[2], e2[1]);
    p1_d[1] = cross_term(dv0[2], e2[0], dv0[0], e2[2]);
    p1_d[2] = cross_term(dv0[0], e2[1], dv0[1], e2[0]);
    q1_d[0] = cross_term(tv0_q[1], e1[2], tv0_q[2], e1[1]);
    q1_d[1] = cross_term(tv0_q[2], e1[0], tv0_q[0], e1[2]);
    q1_d[2] = cross_term(tv0_q[0], e1[1], tv0_q[1], e1[0]);
  end

  // stage 2: dot product terms
  ray_in_t r2_q;
  dot_t [2:0] det2_q, nt2_q, nx2_q, ny2_q;
  dot_t [2:0] det2_d, nt2_d, nx2_d, ny2_d;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      det2_d[i] = dot_t'(p1_q[i]) * dot_t'(e1[i]);
      nt2_d[i]  = dot_t'(q1_q[i]) * dot_t'(e2[i]);
      nx2_d[i]  = dot_t'(p1_q[i]) * dot_t'(tv1_q[i]);
      ny2_d[i]  = dot_t'(q1_q[i]) * dot_t'(r1_q.dir[i]);
    end
  end

  // stage 3: sums
  ray_in_t r3_q;
  dot_t det3_q, nt3_q, nx3_q, ny3_q;

  // stage 4: make det positive, classify
  dot_t det_n, nt_n, nx_n, ny_n;
  logic signed [DOTW:0] nxy;
  ray_job_t job_d, job_q;
  always_comb begin
    if (det3_q < 0) begin
      det_n = -det3_q;
      nt_n  = -nt3_q;
      nx_n  = -nx3_q;
      ny_n  = -ny3_q;
    end else begin
      det_n = det3_q;
      nt_n  = nt3_q;
      nx_n  = nx3_q;
      ny_n  = ny3_q;
    end
    nxy = (DOTW+1)'(nx_n) + (DOTW+1)'(ny_n);
    job_d.ray = r3_q;
    job_d.det = det_n;
    job_d.nt  = nt_n;
    job_d.nx  = nx_n;
    job_d.ny  = ny_n;
    job_d.early_miss = (det_n <= DET_EPS) || (nx_n < 0) || (nx_n > det_n) || (ny_n < 0)
                       || (nxy > (DOTW+1)'(det_n));
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      r0_q   <= ray_i;
      tv0_q  <= tv0_d;
      r1_q   <= r0_q;
      tv1_q  <= tv0_q;
      p1_q   <= p1_d;
      q1_q   <= q1_d;
      r2_q   <= r1_q;
      det2_q <= det2_d;
      nt2_q  <= nt2_d;
      nx2_q  <= nx2_d;
      ny2_q  <= ny2_d;
      r3_q   <= r2_q;
      det3_q <= det2_q[0] + det2_q[1] + det2_q[2];
      nt3_q  <= nt2_q[0] + nt2_q[1] + nt2_q[2];
      nx3_q  <= nx2_q[0] + nx2_q[1] + nx2_q[2];
      ny3_q  <= ny2_q[0] + ny2_q[1] + ny2_q[2];
      job_q  <= job_d;
    end
  end

  assign job_valid_o = v4_q;
  assign job_o       = job_q;

endmodule

`default_nettype wire

// ----- sv/rti_queue.sv -----
// Two-entry queue of classified ray jobs between front and back.
`default_nettype none

module rti_queue import rti_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire ray_job_t item_i,
  output logic          full_o,
  output logic          valid_o,
  output ray_job_t      item_o
);

  ray_job_t mem_q [2];
  logic wptr_q, rptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic pop;

  assign pop     = (cnt_q != 2'd0);
  assign valid_o = pop;
  assign full_o  = (cnt_q == 2'd2);
  assign item_o  = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("queue push while full");
  a_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1 && !push_i) |=> (cnt_q == 2'd0))
    else $error("queue did not drain");
`endif

endmodule

`default_nettype wire

// ----- sv/rti_back.sv -----
// Back pipeline: three bit-per-stage dividers, window test, hit point and interpolation.
`default_nettype none

module rti_back import rti_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_t     cfg_i,
  input  wire logic     job_valid_i,
  input  wire ray_job_t job_i,
  output logic          res_valid_o,
  output ray_res_t      res_o
);

  typedef struct packed {
    logic            miss;
    logic            neg;
    logic [DOTW-1:0] det;
    ray_in_t         ray;
  } div_side_t;

  logic      vld_q [QB+1];
  div_side_t side_q [QB+1];
  rem_t      rt_q [QB+1], rb_q [QB+1], rc_q [QB+1];
  logic [QB-1:0] qt_q [QB+1], qb_q [QB+1], qc_q [QB+1];

  // stage 0: numerators, overflow of the t quotient
  logic [DOTW-1:0] nt_mag;
  rem_t num_t;
  div_side_t side0;
  always_comb begin
    nt_mag = (job_i.nt < 0) ? -job_i.nt : job_i.nt;
    num_t  = rem_t'(nt_mag) << CF;
    side0.neg  = (job_i.nt < 0);
    side0.det  = job_i.det;
    side0.ray  = job_i.ray;
    side0.miss = job_i.early_miss || (num_t >= (rem_t'(job_i.det) << QB));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= job_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side0;
    rt_q[0]   <= num_t;
    rb_q[0]   <= rem_t'(job_i.nx[DOTW-2:0]) << WF;
    rc_q[0]   <= rem_t'(job_i.ny[DOTW-2:0]) << WF;
    qt_q[0]   <= '0;
    qb_q[0]   <= '0;
    qc_q[0]   <= '0;
  end

  for (genvar s = 1; s <= QB; s++) begin : g_div
    localparam int SH = QB - s;
    rem_t dsh;
    div_step_t st_t, st_b, st_c;
    always_comb begin
      dsh  = rem_t'(side_q[s-1].det) << SH;
      st_t = div_step(rt_q[s-1], dsh);
      st_b = div_step(rb_q[s-1], dsh);
      st_c = div_step(rc_q[s-1], dsh);
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_q[s-1];
      end
    end
    always_ff @(posedge clk_i) begin
      side_q[s] <= side_q[s-1];
      rt_q[s]   <= st_t.rem;
      rb_q[s]   <= st_b.rem;
      rc_q[s]   <= st_c.rem;
      qt_q[s]   <= qt_q[s-1] | (QB'(st_t.take) << SH);
      qb_q[s]   <= qb_q[s-1] | (QB'(st_b.take) << SH);
      qc_q[s]   <= qc_q[s-1] | (QB'(st_c.take) << SH);
    end
  end

  // check stage: floor quotient, open t window, weights
  div_side_t sd;
  logic rnz, lower_ok, upper_ok;
  logic signed [QB+1:0] t_mag, t_full, tl_x, tu_x;
  wgt_t wb_w, wc_w, wa_w;
  always_comb begin
    sd     = side_q[QB];
    rnz    = |rt_q[QB];
    t_mag  = {2'b00, qt_q[QB]};
    t_full = sd.neg ? (-t_mag - (QB+2)'(rnz)) : t_mag;
    tl_x   = (QB+2)'(sd.ray.t_lo);
    tu_x   = (QB+2)'(sd.ray.t_hi);
    lower_ok = (t_full > tl_x) || ((t_full == tl_x) && rnz);
    upper_ok = (t_full < tu_x);
    wb_w = wgt_t'({1'b0, qb_q[QB][WF:0]});
    wc_w = wgt_t'({1'b0, qc_q[QB][WF:0]});
    wa_w = wgt_t'(1 << WF) - wb_w - wc_w;
  end

  logic c_vld_q, c_hit_q;
  coord_t c_t_q;
  coord_t [2:0] c_org_q, c_dir_q;
  wgt_t [2:0] c_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= vld_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    c_hit_q  <= !sd.miss && lower_ok && upper_ok;
    c_t_q    <= t_full[CW-1:0];
    c_org_q  <= sd.ray.org;
    c_dir_q  <= sd.ray.dir;
    c_w_q[0] <= wa_w;
    c_w_q[1] <= wb_w;
    c_w_q[2] <= wc_w;
  end

  // multiply stage
  attr_t att [NATTR][3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      att[k][0] = cfg_i.na[k];
      att[k][1] = cfg_i.nb[k];
      att[k][2] = cfg_i.nc[k];
    end
    for (int k = 0; k < 2; k++) begin
      att[3+k][0] = cfg_i.ta[k];
      att[3+k][1] = cfg_i.tb[k];
      att[3+k][2] = cfg_i.tc[k];
    end
  end

  logic m_vld_q, m_hit_q;
  coord_t m_t_q;
  coord_t [2:0] m_org_q;
  logic signed [TPW-1:0] m_tdv_q [3];
  logic signed [LPW-1:0] m_lp_q [NATTR][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m_hit_q <= c_hit_q;
    m_t_q   <= c_t_q;
    m_org_q <= c_org_q;
    for (int i = 0; i < 3; i++) begin
      m_tdv_q[i] <= TPW'(c_t_q) * TPW'(c_dir_q[i]);
    end
    for (int k = 0; k < NATTR; k++) begin
      for (int j = 0; j < 3; j++) begin
        m_lp_q[k][j] <= LPW'(c_w_q[j]) * LPW'(att[k][j]);
      end
    end
  end

  // output stage: floor shifts, saturation, zero on miss
  logic signed [TPW:0] psum [3];
  logic signed [LSW-1:0] lsum [NATTR];
  ray_res_t res_d, res_q;
  logic done_q;
  always_comb begin
    res_d = '0;
    for (int i = 0; i < 3; i++) begin
      psum[i] = (TPW+1)'(m_org_q[i]) + ((TPW+1)'(m_tdv_q[i]) >>> CF);
    end
    for (int k = 0; k < NATTR; k++) begin
      lsum[k] = (LSW'(m_lp_q[k][0]) + LSW'(m_lp_q[k][1]) + LSW'(m_lp_q[k][2])) >>> WF;
    end
    if (m_hit_q) begin
      res_d.hit = 1'b1;
      res_d.t   = m_t_q;
      for (int i = 0; i < 3; i++) begin
        res_d.point[i] = sat_coord(psum[i]);
        res_d.shade[i] = sat_attr(lsum[i]);
      end
      res_d.tex[0] = sat_attr(lsum[3]);
      res_d.tex[1] = sat_attr(lsum[4]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      res_q  <= '0;
    end else begin
      done_q <= m_vld_q;
      res_q  <= m_vld_q ? res_d : '0;
    end
  end

  assign res_valid_o = done_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ----- sv/ray_triangle_intersect.sv -----
// Top level: configuration registers, front pipeline, job queue and back pipeline.
// Throughput: one ray per cycle; the back drains the queue every cycle, so busy stays low.
// The 21-stage restoring dividers (one quotient bit per stage) set the latency.
// Reset clears all triangle registers to zero and empties every pipeline stage.
// Results cannot be held off: each is on the ports for exactly one cycle with done_o.
`default_nettype none

module ray_triangle_intersect import rti_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [3:0]    cfg_idx_i,
  input  wire logic [63:0]   cfg_wdata_i,
  input  wire logic          start,
  output logic               busy,
  input  wire logic signed [CW-1:0] origin_x_i,
  input  wire logic signed [CW-1:0] origin_y_i,
  input  wire logic signed [CW-1:0] origin_z_i,
  input  wire logic signed [CW-1:0] dir_x_i,
  input  wire logic signed [CW-1:0] dir_y_i,
  input  wire logic signed [CW-1:0] dir_z_i,
  input  wire logic signed [CW-1:0] t_lower_i,
  input  wire logic signed [CW-1:0] t_upper_i,
  output logic               done_o,
  output logic               is_hit_o,
  output logic signed [CW-1:0] hit_t_o,
  output logic signed [CW-1:0] point_x_o,
  output logic signed [CW-1:0] point_y_o,
  output logic signed [CW-1:0] point_z_o,
  output logic signed [NW-1:0] shade_nx_o,
  output logic signed [NW-1:0] shade_ny_o,
  output logic signed [NW-1:0] shade_nz_o,
  output logic signed [NW-1:0] tex_u_o,
  output logic signed [NW-1:0] tex_v_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_VERTEX_A:    cfg_q.va <= cfg_wdata_i[3*CW-1:0];
        REG_VERTEX_B:    cfg_q.vb <= cfg_wdata_i[3*CW-1:0];
        REG_VERTEX_C:    cfg_q.vc <= cfg_wdata_i[3*CW-1:0];
        REG_NORMAL_A:    cfg_q.na <= cfg_wdata_i[3*NW-1:0];
        REG_NORMAL_B:    cfg_q.nb <= cfg_wdata_i[3*NW-1:0];
        REG_NORMAL_C:    cfg_q.nc <= cfg_wdata_i[3*NW-1:0];
        REG_TEXCOORD_AB: begin
          cfg_q.ta <= cfg_wdata_i[2*NW-1:0];
          cfg_q.tb <= cfg_wdata_i[4*NW-1:2*NW];
        end
        REG_TEXCOORD_C:  cfg_q.tc <= cfg_wdata_i[2*NW-1:0];
        default: ;
      endcase
    end
  end

  ray_in_t  ray;
  ray_job_t job_f, job_b;
  ray_res_t res;
  logic q_full, job_f_valid, job_b_valid, take;

  always_comb begin
    ray.org[0] = origin_x_i;
    ray.org[1] = origin_y_i;
    ray.org[2] = origin_z_i;
    ray.dir[0] = dir_x_i;
    ray.dir[1] = dir_y_i;
    ray.dir[2] = dir_z_i;
    ray.t_lo   = t_lower_i;
    ray.t_hi   = t_upper_i;
  end

  assign busy = q_full;
  assign take = start && !q_full;

  rti_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .adv_i       (!q_full),
    .take_i      (take),
    .ray_i       (ray),
    .job_valid_o (job_f_valid),
    .job_o       (job_f)
  );

  rti_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_f_valid && !q_full),
    .item_i  (job_f),
    .full_o  (q_full),
    .valid_o (job_b_valid),
    .item_o  (job_b)
  );

  rti_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_b_valid),
    .job_i       (job_b),
    .res_valid_o (done_o),
    .res_o       (res)
  );

  assign is_hit_o   = res.hit;
  assign hit_t_o    = res.t;
  assign point_x_o  = res.point[0];
  assign point_y_o  = res.point[1];
  assign point_z_o  = res.point[2];
  assign shade_nx_o = res.shade[0];
  assign shade_ny_o = res.shade[1];
  assign shade_nz_o = res.shade[2];
  assign tex_u_o    = res.tex[0];
  assign tex_v_o    = res.tex[1];

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !is_hit_o) |-> (hit_t_o == '0 && point_x_o == '0 && point_y_o == '0 &&
      point_z_o == '0 && shade_nx_o == '0 && tex_u_o == '0 && tex_v_o == '0))
    else $error("miss item carries nonzero fields");
  a_hit_strobed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_hit_o |-> done_o)
    else $error("hit flag without done strobe");
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("front stalled on a full queue");
`endif

endmodule

`default_nettype wire

// ----- sim/ray_triangle_intersect_tb.sv -----
// Self-checking testbench for the ray/triangle intersection unit.
`default_nettype none

module ray_triangle_intersect_tb;
  import rti_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    ray_in_t     ray;
    int unsigned gap;
    bit          drain;
  } ray_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [3:0]  cfg_idx_i = '0;
  logic [63:0] cfg_wdata_i = '0;
  logic        start = 1'b0;
  logic        busy;
  coord_t      origin_x_i = '0, origin_y_i = '0, origin_z_i = '0;
  coord_t      dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  coord_t      t_lower_i = '0, t_upper_i = '0;
  logic        done_o, is_hit_o;
  coord_t      hit_t_o, point_x_o, point_y_o, point_z_o;
  attr_t       shade_nx_o, shade_ny_o, shade_nz_o, tex_u_o, tex_v_o;

  ray_triangle_intersect dut (.*);

  always #6 clk_i = ~clk_i;

  logic [63:0] tri_reg [8];
  ray_item_t   ray_q[$];
  ray_res_t    hit_q[$];
  int unsigned wait_cnt = 0;
  int          mismatches = 0;

  function automatic longint sat_w(longint v, int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  function automatic wide_t dot3(longint x[3], longint y[3]);
    return wide_t'(x[0]) * wide_t'(y[0]) + wide_t'(x[1]) * wide_t'(y[1])
         + wide_t'(x[2]) * wide_t'(y[2]);
  endfunction

  function automatic void cross3(longint x[3], longint y[3], output longint r[3]);
    r[0] = x[1] * y[2] - x[2] * y[1];
    r[1] = x[2] * y[0] - x[0] * y[2];
    r[2] = x[0] * y[1] - x[1] * y[0];
  endfunction

  function automatic longint vtx(int k, int i);
    return longint'(coord_t'(tri_reg[k] >> (i * CW)));
  endfunction

  function automatic longint blend(longint wa, longint wb, longint wc,
                                   longint a, longint b, longint c);
    return sat_w((wa * a + wb * b + wc * c) >>> WF, NW);
  endfunction

  function automatic ray_res_t trace_ray(ray_in_t r);
    longint   o[3], d[3], e1[3], e2[3], tv[3], p[3], q[3];
    wide_t    det, nt, nx, ny, m, tq;
    longint   t, wa, wb, wc;
    ray_res_t res;
    res = '0;
    for (int i = 0; i < 3; i++) begin
      o[i]  = r.org[i];
      d[i]  = r.dir[i];
      e1[i] = vtx(int'(REG_VERTEX_B), i) - vtx(int'(REG_VERTEX_A), i);
      e2[i] = vtx(int'(REG_VERTEX_C), i) - vtx(int'(REG_VERTEX_A), i);
      tv[i] = o[i] - vtx(int'(REG_VERTEX_A), i);
    end
    cross3(d, e2, p);
    cross3(tv, e1, q);
    det = dot3(p, e1);
    nt  = dot3(q, e2);
    nx  = dot3(p, tv);
    ny  = dot3(q, d);
    if (det < 0) begin
      det = -det; nt = -nt; nx = -nx; ny = -ny;
    end
    if (det <= wide_t'(DET_EPS)) return res;
    m = nt * 256;
    if (m <= wide_t'(r.t_lo) * det || m >= wide_t'(r.t_hi) * det) return res;
    if (nx < 0 || nx > det || ny < 0 || nx + ny > det) return res;
    tq = m / det;
    if (m < 0 && tq * det != m) tq = tq - 1;
    t  = longint'(tq);
    wb = longint'((nx * 65536) / det);
    wc = longint'((ny * 65536) / det);
    wa = 65536 - wb - wc;
    res.hit = 1'b1;
    res.t   = coord_t'(t);
    for (int i = 0; i < 3; i++) begin
      res.point[i] = coord_t'(sat_w(o[i] + ((t * d[i]) >>> CF), CW));
      res.shade[i] = attr_t'(blend(wa, wb, wc,
                       longint'(attr_t'(tri_reg[REG_NORMAL_A] >> (i * NW))),
                       longint'(attr_t'(tri_reg[REG_NORMAL_B] >> (i * NW))),
                       longint'(attr_t'(tri_reg[REG_NORMAL_C] >> (i * NW)))));
    end
    for (int i = 0; i < 2; i++)
      res.tex[i] = attr_t'(blend(wa, wb, wc,
                     longint'(attr_t'(tri_reg[REG_TEXCOORD_AB] >> (i * NW))),
                     longint'(attr_t'(tri_reg[REG_TEXCOORD_AB] >> (i * NW + 32))),
                     longint'(attr_t'(tri_reg[REG_TEXCOORD_C] >> (i * NW)))));
    return res;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    ray_item_t it;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) hit_q.push_back(trace_ray(
        '{org: '{origin_z_i, origin_y_i, origin_x_i},
          dir: '{dir_z_i, dir_y_i, dir_x_i}, t_lo: t_lower_i, t_hi: t_upper_i}));
      if (start && busy) begin
      end else if (wait_cnt > 0) begin
        start <= 1'b0;
        wait_cnt <= wait_cnt - 1;
      end else if (ray_q.size() > 0 && !(ray_q[0].drain && hit_q.size() > 0)) begin
        it = ray_q.pop_front();
        origin_x_i <= it.ray.org[0];
        origin_y_i <= it.ray.org[1];
        origin_z_i <= it.ray.org[2];
        dir_x_i    <= it.ray.dir[0];
        dir_y_i    <= it.ray.dir[1];
        dir_z_i    <= it.ray.dir[2];
        t_lower_i  <= it.ray.t_lo;
        t_upper_i  <= it.ray.t_hi;
        start      <= 1'b1;
        wait_cnt   <= it.gap;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    ray_res_t exp_r, got;
    if (rst_ni && done_o) begin
      got = '{is_hit_o, hit_t_o, '{point_z_o, point_y_o, point_x_o},
              '{shade_nz_o, shade_ny_o, shade_nx_o}, '{tex_v_o, tex_u_o}};
      if (hit_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        exp_r = hit_q.pop_front();
        if (got.hit !== exp_r.hit || got.t !== exp_r.t || got.point !== exp_r.point
            || got.shade !== exp_r.shade || got.tex !== exp_r.tex) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch\n  exp %p\n  got %p", exp_r, got);
        end
      end
    end
  end

  function automatic logic [63:0] pack3(longint x, longint y, longint z, int w);
    logic [63:0] mk;
    mk = (64'd1 << w) - 1;
    return (64'(x) & mk) | ((64'(y) & mk) << w) | ((64'(z) & mk) << (2 * w));
  endfunction

  function automatic longint srand(longint s);
    return longint'($urandom_range(0, 2 * s)) - s;
  endfunction

  task automatic set_reg(cfg_reg_e idx, logic [63:0] v);
    logic [63:0] mk;
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    case (idx)
      REG_VERTEX_A, REG_VERTEX_B, REG_VERTEX_C: mk = (64'd1 << (3 * CW)) - 1;
      REG_NORMAL_A, REG_NORMAL_B, REG_NORMAL_C: mk = (64'd1 << 48) - 1;
      REG_TEXCOORD_C: mk = 64'hFFFF_FFFF;
      default: mk = '1;
    endcase
    tri_reg[idx] = v & mk;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (ray_q.size() != 0 || start || wait_cnt != 0 || hit_q.size() != 0)
      @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic add_ray(longint ox, longint oy, longint oz, longint dx, longint dy,
                         longint dz, longint tl, longint tu, int unsigned gap, bit drain);
    ray_item_t it;
    it.ray.org = '{coord_t'(oz), coord_t'(oy), coord_t'(ox)};
    it.ray.dir = '{coord_t'(dz), coord_t'(dy), coord_t'(dx)};
    it.ray.t_lo = coord_t'(tl);
    it.ray.t_hi = coord_t'(tu);
    it.gap = gap;
    it.drain = drain;
    ray_q.push_back(it);
  endtask

  // ray through a random point of the current triangle at t of about 1.0
  task automatic aim_ray(int unsigned gap, bit drain);
    longint b, c, tgt[3], d[3], tl, tu;
    b = $urandom_range(0, 256);
    c = $urandom_range(0, 256 - b);
    for (int i = 0; i < 3; i++) begin
      tgt[i] = vtx(0, i) + ((b * (vtx(1, i) - vtx(0, i)) + c * (vtx(2, i) - vtx(0, i))) >>> 8);
      d[i] = srand(longint'(1) << $urandom_range(2, 15));
    end
    tl = 256 - longint'($urandom_range(1, 700));
    tu = ($urandom_range(0, 9) == 0) ? 256 - longint'($urandom_range(0, 20))
                                      : 256 + longint'($urandom_range(1, 700));
    add_ray(sat_w(tgt[0] - d[0], CW), sat_w(tgt[1] - d[1], CW), sat_w(tgt[2] - d[2], CW),
            d[0], d[1], d[2], tl, tu, gap, drain);
  endtask

  function automatic longint pick_coord(int mode);
    case (mode)
      1: return longint'(coord_t'($urandom));
      3: case ($urandom_range(0, 3))
           0: return 524287;
           1: return -524288;
           2: return 0;
           default: return longint'(coord_t'($urandom));
         endcase
      default: return srand(4096);
    endcase
  endfunction

  function automatic longint pick_attr(bit hard);
    if (hard && $urandom_range(0, 2) != 0) return $urandom_range(0, 1) ? 32767 : -32768;
    return longint'(attr_t'($urandom));
  endfunction

  initial begin
    longint  cx[3];
    bit      calm;
    cfg_reg_e r;
    for (int k = 0; k < 8; k++) tri_reg[k] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset triangle is degenerate: everything misses
    add_ray(524287, 524287, 524287, 524287, 524287, 524287, 524287, 524287, 0, 0);
    add_ray(-524288, -524288, -524288, -524288, -524288, -524288, -524288, -524288, 3, 0);
    add_ray(64, 64, -256, 0, 0, 256, 0, 512, 0, 0);
    wait_idle();

    // unit right triangle in the z=0 plane
    set_reg(REG_VERTEX_A, pack3(0, 0, 0, CW));
    set_reg(REG_VERTEX_B, pack3(256, 0, 0, CW));
    set_reg(REG_VERTEX_C, pack3(0, 256, 0, CW));
    set_reg(REG_NORMAL_A, pack3(16384, 0, 0, NW));
    set_reg(REG_NORMAL_B, pack3(0, 16384, 0, NW));
    set_reg(REG_NORMAL_C, pack3(32767, 32767, -32768, NW));
    set_reg(REG_TEXCOORD_AB, {16'sd4096, 16'sd0, 16'sd0, 16'sd4096});
    set_reg(REG_TEXCOORD_C, {16'h8000, 16'h7FFF});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    add_ray(64, 64, -256, 0, 0, 256, 0, 512, 0, 0);
    add_ray(0, 0, -256, 0, 0, 256, 0, 512, 0, 0);
    add_ray(256, 0, -256, 0, 0, 256, 0, 512, 1, 0);
    add_ray(0, 256, -256, 0, 0, 256, 0, 512, 0, 0);
    add_ray(128, 128, -256, 0, 0, 256, 0, 512, 2, 0);
    add_ray(129, 128, -256, 0, 0, 256, 0, 512, 0, 0);
    add_ray(-1, 64, -256, 0, 0, 256, 0, 512, 0, 0);
    add_ray(64, 64, -256, 256, 0, 0, -524288, 524287, 0, 0);
    add_ray(64, 64, -256, 0, 0, 256, 256, 512, 0, 0);
    add_ray(64, 64, -256, 0, 0, 256, 0, 256, 0, 0);
    add_ray(64, 64, -256, 0, 0, 256, 512, 0, 0, 0);
    add_ray(64, 64, 256, 0, 0, -256, 0, 512, 0, 0);
    add_ray(64, 64, 256, 0, 0, 256, -512, 0, 0, 0);
    add_ray(64, 64, -256, 0, 0, 524287, -524288, 524287, 0, 0);
    add_ray(64, 64, -524288, 0, 0, 1, -524288, 524287, 0, 0);
    add_ray(-524288, 524287, -256, 524287, -524288, 256, -524288, 524287, 0, 0);
    wait_idle();

    calm = 0;
    for (int ph = 0; ph < 6; ph++) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) cx[i] = pick_coord(ph % 4);
        r = cfg_reg_e'(k);
        set_reg(r, pack3(cx[0], cx[1], cx[2], CW) | (64'($urandom_range(0, 15)) << 60));
      end
      for (int k = 3; k < 6; k++) begin
        r = cfg_reg_e'(k);
        set_reg(r, pack3(pick_attr(ph % 2 == 1), pick_attr(ph % 2 == 1),
                         pick_attr(ph % 2 == 1), NW) | ({$urandom, $urandom} & ~64'hFFFF_FFFF_FFFF));
      end
      set_reg(REG_TEXCOORD_AB, pack3(pick_attr(ph > 2), pick_attr(ph > 2), pick_attr(ph > 2), NW)
                               | (64'(pick_attr(ph > 2)) << 48));
      set_reg(REG_TEXCOORD_C, {$urandom, $urandom});
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= 4'($urandom_range(8, 15));
      cfg_wdata_i <= {$urandom, $urandom};
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      for (int n = 0; n < 205; n++) begin
        int unsigned g;
        bit dr;
        if ($urandom_range(0, 49) == 0) calm = !calm;
        g  = calm ? 0 : $urandom_range(0, 9);
        dr = ($urandom_range(0, 99) == 0);
        if ($urandom_range(0, 9) < 7) aim_ray(g, dr);
        else add_ray(longint'(coord_t'($urandom)), longint'(coord_t'($urandom)),
                     longint'(coord_t'($urandom)), longint'(coord_t'($urandom)),
                     longint'(coord_t'($urandom)), longint'(coord_t'($urandom)),
                     longint'(coord_t'($urandom)), longint'(coord_t'($urandom)), g, dr);
      end
      wait_idle();
    end

    // collinear vertices
    set_reg(REG_VERTEX_A, pack3(0, 0, 0, CW));
    set_reg(REG_VERTEX_B, pack3(256, 256, 256, CW));
    set_reg(REG_VERTEX_C, pack3(512, 512, 512, CW));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    for (int n = 0; n < 30; n++) aim_ray($urandom_range(0, 9), 0);
    wait_idle();

    if (mismatches == 0 && hit_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #4800000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
sv/rti_pkg.sv
sv/rti_front.sv
sv/rti_queue.sv
sv/rti_back.sv
sv/ray_triangle_intersect.sv
sim/ray_triangle_intersect_tb.sv
